FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, muted while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ksle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksle_pkg
// Types, codes and the key table of the scan line editor.
// ----------------------------------------------------------------------------
package ksle_pkg;

  localparam int MAX_LINE   = 63;
  localparam int LINE_LEN_W = $clog2(MAX_LINE + 1);
  localparam int LINE_AW    = $clog2(MAX_LINE);

  // command queue between front and back, depth must be a power of two
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_FIFO_AW    = $clog2(CMD_FIFO_DEPTH);

  localparam int TABLE_SIZE = 60;

  localparam logic [6:0] CODE_BACKSPACE = 7'h0E;
  localparam logic [6:0] CODE_ENTER     = 7'h1C;
  localparam logic [6:0] CODE_LSHIFT    = 7'd42;
  localparam logic [6:0] CODE_RSHIFT    = 7'd54;
  localparam logic [6:0] CODE_CAPS      = 7'd58;

  localparam logic [2:0] MODE_SHELL    = 3'd2;
  localparam logic [2:0] MODE_PASSWORD = 3'd3;
  localparam logic [2:0] MODE_NEWLINE  = 3'd4;

  localparam logic       REG_INPUT_ENABLE = 1'b0;
  localparam logic       REG_TEXT_MODE    = 1'b1;

  localparam logic [7:0] CHAR_MASK    = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // first character of each string is key code 0; \010 is backspace,
  // \140 is the backtick glyph
  localparam logic [8*TABLE_SIZE-1:0] PLAIN_COL =
    "  1234567890-=\010 qwertyuiop[]\n asdfghjkl;'\140 \\zxcvbnm,./ *    ";
  localparam logic [8*TABLE_SIZE-1:0] SHIFT_COL =
    "  !@#$%^&*()_+\010 QWERTYUIOP{}\n ASDFGHJKL:\"~ |ZXCVBNM<>?      ";

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_ERASE = 2'd1,
    OP_ENTER = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_code;
    logic       target;
    logic       last;
  } result_t;

  function automatic logic [7:0] key_char(logic [6:0] code, logic shifted);
    int         pos;
    logic [7:0] ch;
    pos = TABLE_SIZE - 1 - int'(code);
    ch  = 8'h00;
    if (code < 7'(TABLE_SIZE)) begin
      ch = shifted ? SHIFT_COL[8*pos +: 8] : PLAIN_COL[8*pos +: 8];
    end
    return ch;
  endfunction

endpackage

FILE: design/ksle_scan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksle_scan_if
// Scan byte channel: valid/ready with one raw set-1 byte.
// ----------------------------------------------------------------------------
interface ksle_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

FILE: design/ksle_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksle_result_if
// Result channel: valid/ready with one editor result.
// ----------------------------------------------------------------------------
interface ksle_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic       target;
  logic       last;

  modport source (output valid, output kind, output char_code, output target,
                  output last, input ready);
  modport sink   (input valid, input kind, input char_code, input target,
                  input last, output ready);
endinterface

FILE: design/ksle_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksle_cmd_fifo
// Short command queue that decouples the front decoder from the back end.
// ----------------------------------------------------------------------------
module ksle_cmd_fifo import ksle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t                   slot_q [CMD_FIFO_DEPTH];
  logic [CMD_FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_FIFO_AW:0]   count_q, count_d;
  logic                   do_push, do_pop;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == (CMD_FIFO_AW+1)'(CMD_FIFO_DEPTH));
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: design/ksle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksle_front
// Accepts scan bytes, tracks pressed keys and modifiers, emits edit commands.
// ----------------------------------------------------------------------------
module ksle_front import ksle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  ksle_scan_if.sink        scan_i,
  input  logic             input_enable_i,
  input  logic [2:0]       text_mode_i,
  input  logic             fifo_full_i,
  output logic             push_o,
  output cmd_t             push_cmd_o
);

  logic [127:0] pressed_q;
  logic         shift_q, shift_d;
  logic         caps_q, caps_d;
  logic         busy_q;
  logic [7:0]   byte_q;
  logic         hit_q;
  logic         accept, done, press, fresh, act, is_shift, text_on;
  logic [6:0]   code, code_in;

  // one byte held at a time; the pressed map is read at the transfer edge
  // and updated when the byte is classified, so no bypass is needed
  assign scan_i.ready = !busy_q;
  assign accept       = scan_i.valid && scan_i.ready;
  assign done         = busy_q && !fifo_full_i;
  assign code_in      = scan_i.scan_byte[6:0];
  assign code         = byte_q[6:0];
  assign press        = !byte_q[7];
  assign fresh        = press && !hit_q;
  assign act          = done && fresh && input_enable_i;
  assign is_shift     = (code == CODE_LSHIFT) || (code == CODE_RSHIFT);
  assign text_on      = (text_mode_i == MODE_SHELL) || (text_mode_i == MODE_PASSWORD);

  always_comb begin
    push_o        = 1'b0;
    push_cmd_o.op = OP_CHAR;
    push_cmd_o.ch = key_char(code, shift_q || caps_q);
    shift_d       = shift_q;
    caps_d        = caps_q;
    if (done && !press && input_enable_i && is_shift) begin
      shift_d = 1'b0;
    end
    if (act) begin
      if (code == CODE_BACKSPACE) begin
        push_o        = 1'b1;
        push_cmd_o.op = OP_ERASE;
      end else if (is_shift) begin
        shift_d = 1'b1;
      end else if (code == CODE_CAPS) begin
        caps_d = !caps_q;
      end else if (code == CODE_ENTER) begin
        push_o        = 1'b1;
        push_cmd_o.op = OP_ENTER;
      end else if (code < 7'(TABLE_SIZE) && text_on) begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
      shift_q   <= 1'b0;
      caps_q    <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      if (done) begin
        pressed_q[code] <= press;
      end
      shift_q <= shift_d;
      caps_q  <= caps_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
    end
  end

  // byte holding register and registered pressed-map read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= scan_i.scan_byte;
      hit_q  <= pressed_q[code_in];
    end
  end

endmodule

FILE: design/ksle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksle_back
// Executes edit commands against the line store and drives the result port.
// ----------------------------------------------------------------------------
module ksle_back import ksle_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [2:0]    text_mode_i,
  input  logic          fifo_empty_i,
  input  cmd_t          fifo_cmd_i,
  output logic          pop_o,
  ksle_result_if.source result_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PUT  = 4'b0010,
    ST_READ = 4'b0100,
    ST_RUN  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [LINE_LEN_W-1:0] len_q, len_d;
  logic [LINE_LEN_W-1:0] run_len_q, run_len_d;
  logic [LINE_AW-1:0]    idx_q, idx_d;
  result_t               pend_q, pend_d;
  result_t               out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            line_mem [MAX_LINE];
  logic [7:0]            rdata_q;
  logic                  mem_we;
  logic                  slot_free, text_on, tgt, run_last;

  assign slot_free = !out_valid_q || result_o.ready;
  assign text_on   = (text_mode_i == MODE_SHELL) || (text_mode_i == MODE_PASSWORD);
  assign tgt       = (text_mode_i == MODE_PASSWORD);
  assign run_last  = (LINE_LEN_W'(idx_q) + LINE_LEN_W'(1)) == run_len_q;
  assign pop_o     = (state_q == ST_IDLE) && !fifo_empty_i;

  assign result_o.valid     = out_valid_q;
  assign result_o.kind      = out_q.kind;
  assign result_o.char_code = out_q.char_code;
  assign result_o.target    = out_q.target;
  assign result_o.last      = out_q.last;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    run_len_d   = run_len_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_o.ready;
    mem_we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          case (fifo_cmd_i.op)
            OP_CHAR: begin
              if (len_q < LINE_LEN_W'(MAX_LINE)) begin
                mem_we  = 1'b1;
                len_d   = len_q + 1'b1;
                pend_d  = '{KIND_ECHO, tgt ? CHAR_MASK : fifo_cmd_i.ch, 1'b0, 1'b0};
                state_d = ST_PUT;
              end
            end
            OP_ERASE: begin
              if (len_q != '0) begin
                len_d   = len_q - 1'b1;
                pend_d  = '{KIND_ERASE, 8'h00, 1'b0, 1'b0};
                state_d = ST_PUT;
              end
            end
            OP_ENTER: begin
              len_d = '0;
              if (text_on) begin
                if (len_q == '0) begin
                  pend_d  = '{KIND_EMPTY, 8'h00, tgt, 1'b1};
                  state_d = ST_PUT;
                end else begin
                  idx_d     = '0;
                  run_len_d = len_q;
                  state_d   = ST_READ;
                end
              end else if (text_mode_i == MODE_NEWLINE) begin
                pend_d  = '{KIND_ECHO, CHAR_NEWLINE, 1'b0, 1'b0};
                state_d = ST_PUT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          state_d     = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{KIND_LINE, rdata_q, tgt, run_last};
          if (run_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_len_q <= run_len_d;
    idx_q     <= idx_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  // line store: one write port at the fill point, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[len_q[LINE_AW-1:0]] <= fifo_cmd_i.ch;
    end
    rdata_q <= line_mem[idx_q];
  end

endmodule

FILE: design/keyboard_scan_line_editor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scan_line_editor_core
// Set-1 scan code line editor with shell/password echo and line submission.
// ----------------------------------------------------------------------------
// Raw set-1 scan bytes come in on scan_i (bit 7 = release). The front end
// holds one byte at a time: the transfer edge also reads the 128-key pressed
// map, and the front end then classifies the held byte (auto-repeat presses
// are dropped), updates shift and caps lock and turns backspace, enter and
// character keys into commands. Classification waits while the two-entry
// command queue is full, which holds the input off. The back end runs
// commands against a 63-byte line store and sends results out through an
// output register on result_o. A character or erase result passes from the
// idle state through the put state to the output register; an enter on a
// line of N characters streams N results, one store read per character
// through the single read port of the line store. No clearing pass runs
// after reset: the line store is only read below the current fill point.
// Configuration (input_enable at 0x0, text_mode at 0x4) is to be written
// over APB only while the block is idle; the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module keyboard_scan_line_editor_core import ksle_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ksle_scan_if.sink     scan_i,
  ksle_result_if.source result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic       input_enable_q;
  logic [2:0] text_mode_q;
  logic       cfg_wr;

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       pop_cmd;
  logic       fifo_empty, fifo_full;

  // --- configuration port ---------------------------------------------------
  // Zero wait states; only the word-select bit of paddr decodes a register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_INPUT_ENABLE: prdata = {31'b0, input_enable_q};
      REG_TEXT_MODE:    prdata = {29'b0, text_mode_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_enable_q <= 1'b1;
      text_mode_q    <= 3'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TEXT_MODE) begin
        text_mode_q <= pwdata[2:0];
      end else begin
        input_enable_q <= pwdata[0];
      end
    end
  end

  // --- front: key tracking and classification -------------------------------
  ksle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .scan_i         (scan_i),
    .input_enable_i (input_enable_q),
    .text_mode_i    (text_mode_q),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .push_cmd_o     (push_cmd)
  );

  // --- decoupling queue -----------------------------------------------------
  ksle_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (fifo_empty),
    .full_o     (fifo_full)
  );

  // --- back: line store and result sequencing -------------------------------
  ksle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_mode_i  (text_mode_q),
    .fifo_empty_i (fifo_empty),
    .fifo_cmd_i   (pop_cmd),
    .pop_o        (pop),
    .result_o     (result_o)
  );

endmodule

FILE: design/ksle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksle_checker
// Port-level checks on the result channel of the line editor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksle_checker import ksle_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] res_kind_i,
  input logic [7:0] res_char_i,
  input logic       res_target_i,
  input logic       res_last_i
);

  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_kind_i) && $stable(res_char_i) && $stable(res_last_i), "result dropped while stalled")
  `ASSERT_IMPL(a_erase_fields, clk_i, rst_ni, res_valid_i && res_kind_i == KIND_ERASE, res_char_i == 8'h00 && !res_target_i && !res_last_i, "erase carries data")
  `ASSERT_IMPL(a_echo_fields, clk_i, rst_ni, res_valid_i && res_kind_i == KIND_ECHO, !res_target_i && !res_last_i, "echo marked as submission")
  `ASSERT_IMPL(a_empty_fields, clk_i, rst_ni, res_valid_i && res_kind_i == KIND_EMPTY, res_last_i && res_char_i == 8'h00, "empty line not a lone final item")

endmodule

bind keyboard_scan_line_editor_core ksle_checker u_ksle_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_kind_i   (result_o.kind),
  .res_char_i   (result_o.char_code),
  .res_target_i (result_o.target),
  .res_last_i   (result_o.last)
);
